/* rtl/core/i2crrs_pkg.sv */
// package with item types, codes and defaults for the i2c register read sequencer
`default_nettype none

package i2crrs_pkg;

    localparam int DEFAULT_TIMEOUT_TICKS = 1000;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGISTER_ADDRESS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_LENGTH      = 2'd2;

    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_XFER     = 2'd1;
    localparam logic [1:0] KIND_ARB_LOST = 2'd2;
    localparam logic [1:0] KIND_TICK     = 2'd3;

    localparam logic [2:0] ACT_NONE         = 3'd0;
    localparam logic [2:0] ACT_START_WRITE  = 3'd1;
    localparam logic [2:0] ACT_WRITE        = 3'd2;
    localparam logic [2:0] ACT_RESTART      = 3'd3;
    localparam logic [2:0] ACT_BEGIN_RX     = 3'd4;
    localparam logic [2:0] ACT_CONTINUE_RX  = 3'd5;
    localparam logic [2:0] ACT_STOP         = 3'd6;

    localparam logic [1:0] FIN_NONE    = 2'd0;
    localparam logic [1:0] FIN_SUCCESS = 2'd1;
    localparam logic [1:0] FIN_ERROR   = 2'd2;
    localparam logic [1:0] FIN_TIMEOUT = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ADDR_W = 3'd1,
        PH_REG    = 3'd2,
        PH_ADDR_R = 3'd3,
        PH_DUMMY  = 3'd4,
        PH_DATA   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       nack_received;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        start_refused;
        logic [2:0]  bus_action;
        logic [7:0]  tx_byte;
        logic        send_nack;
        logic        store_valid;
        logic [15:0] store_index;
        logic [7:0]  store_byte;
        logic [1:0]  finished;
        logic [15:0] bytes_done;
        logic [31:0] failure_count;
    } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/i2c_register_read_sequencer.sv */
// top level of the i2c master register read sequencer
//
// s_ channel carries events from the byte-level i2c master: start request,
// byte transfer complete, arbitration lost and microsecond tick. every
// accepted item yields exactly one result item on the m_ channel, telling the
// master what to put on the bus and which received byte to store where.
// cfg channel writes slave address, register address and read length; it is
// always ready and the values are latched into the transaction at start.
// the result is registered: an item accepted at one edge shows on m_ in the next cycle.
// while m_ready is high, one item per cycle is sustained; the single output
// register is refilled in the same cycle it is taken, so s_ready follows
// m_ready when it is full. a stalled receiver holds the result and stops
// intake once the output register is full and not being taken.
// reset (aresetn low, synchronous) returns to idle with counters cleared and
// all configuration registers at zero; no result is pending after reset.
// a transaction times out after TIMEOUT_TICKS ticks without progress.
`default_nettype none

module i2c_register_read_sequencer #(
    parameter int TIMEOUT_TICKS = i2crrs_pkg::DEFAULT_TIMEOUT_TICKS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [i2crrs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [i2crrs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire i2crrs_pkg::in_item_t              s_item,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output i2crrs_pkg::out_item_t                  m_item
);

    localparam int TimerW = $clog2(TIMEOUT_TICKS + 1);
    localparam logic [TimerW-1:0] TimeoutLimit = TimerW'(TIMEOUT_TICKS);

    i2crrs_pkg::phase_t phase_reg, phase_next;
    logic [15:0]       read_count_reg, read_count_next;
    logic [TimerW-1:0] timeout_counter_reg, timeout_counter_next;
    logic              timer_running_reg, timer_running_next;
    logic              nack_armed_reg, nack_armed_next;
    logic [31:0]       error_total_reg, error_total_next;

    logic [6:0]  cfg_slave_reg;
    logic [7:0]  cfg_register_reg;
    logic [15:0] cfg_length_reg;
    logic [6:0]  job_slave_reg;
    logic [7:0]  job_register_reg;
    logic [15:0] job_length_reg;

    logic                  m_valid_reg, m_valid_next;
    i2crrs_pkg::out_item_t m_item_reg, m_item_next;

    logic in_fire;
    logic is_idle;
    logic is_start, is_xfer, is_arb, is_tick;
    logic addr_phase;
    logic data_phase;
    logic start_ok, refused;
    logic fail;
    logic more;
    logic data_store, data_last;
    logic tick_count, timeout_hit;
    logic addr_advance;
    logic finish_evt;
    logic [TimerW-1:0] counter_inc;
    logic        swap_bit;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // event decode
    assign is_idle    = (phase_reg == i2crrs_pkg::PH_IDLE);
    assign is_start   = (s_item.kind == i2crrs_pkg::KIND_START);
    assign is_xfer    = (s_item.kind == i2crrs_pkg::KIND_XFER);
    assign is_arb     = (s_item.kind == i2crrs_pkg::KIND_ARB_LOST);
    assign is_tick    = (s_item.kind == i2crrs_pkg::KIND_TICK);
    assign addr_phase = (phase_reg == i2crrs_pkg::PH_ADDR_W) ||
                        (phase_reg == i2crrs_pkg::PH_REG) ||
                        (phase_reg == i2crrs_pkg::PH_ADDR_R);
    assign data_phase = (phase_reg == i2crrs_pkg::PH_DUMMY) ||
                        (phase_reg == i2crrs_pkg::PH_DATA);

    assign start_ok     = is_start && is_idle && (cfg_length_reg != 16'd0);
    assign refused      = is_start && !is_idle;
    assign addr_advance = is_xfer && addr_phase && !s_item.nack_received;
    assign fail         = (is_xfer && addr_phase && s_item.nack_received) ||
                          (is_arb && !is_idle);
    assign more         = (read_count_reg < (job_length_reg - 16'd1));
    assign data_store   = is_xfer && data_phase;
    assign data_last    = data_store && !more;
    assign counter_inc  = timeout_counter_reg + TimerW'(1);
    assign tick_count   = is_tick && timer_running_reg && !is_idle;
    assign timeout_hit  = tick_count && (counter_inc >= TimeoutLimit);
    assign finish_evt   = fail || data_last || timeout_hit;
    assign swap_bit     = more ? 1'b1 : !job_length_reg[0];

    // next state
    always_comb begin
        phase_next           = phase_reg;
        read_count_next      = read_count_reg;
        timeout_counter_next = timeout_counter_reg;
        timer_running_next   = timer_running_reg;
        nack_armed_next      = nack_armed_reg;
        error_total_next     = error_total_reg;
        if (in_fire) begin
            if (start_ok) begin
                phase_next           = i2crrs_pkg::PH_ADDR_W;
                read_count_next      = 16'd0;
                nack_armed_next      = 1'b0;
                timer_running_next   = 1'b1;
                timeout_counter_next = '0;
            end else if (finish_evt) begin
                phase_next           = i2crrs_pkg::PH_IDLE;
                timer_running_next   = 1'b0;
                timeout_counter_next = '0;
                nack_armed_next      = 1'b0;
                error_total_next     = data_last ? error_total_reg
                                                 : error_total_reg + 32'd1;
                if (data_last) begin
                    read_count_next = read_count_reg + 16'd1;
                end
            end else if (addr_advance) begin
                timer_running_next   = 1'b1;
                timeout_counter_next = '0;
                unique case (phase_reg)
                    i2crrs_pkg::PH_ADDR_W: begin
                        phase_next = i2crrs_pkg::PH_REG;
                    end
                    i2crrs_pkg::PH_REG: begin
                        phase_next = i2crrs_pkg::PH_ADDR_R;
                        if (job_length_reg == 16'd1) begin
                            nack_armed_next = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = i2crrs_pkg::PH_DUMMY;
                    end
                endcase
            end else if (data_store) begin
                phase_next           = i2crrs_pkg::PH_DATA;
                read_count_next      = read_count_reg + 16'd1;
                timer_running_next   = 1'b1;
                timeout_counter_next = '0;
                if (read_count_reg == (job_length_reg - 16'd2)) begin
                    nack_armed_next = 1'b1;
                end
            end else if (tick_count) begin
                timeout_counter_next = counter_inc;
            end
        end
    end

    // result item
    always_comb begin
        m_item_next               = '0;
        m_item_next.start_refused = refused;
        m_item_next.send_nack     = nack_armed_next;
        m_item_next.bytes_done    = read_count_next;
        m_item_next.failure_count = error_total_next;
        priority if (start_ok) begin
            m_item_next.bus_action = i2crrs_pkg::ACT_START_WRITE;
            m_item_next.tx_byte    = {cfg_slave_reg, 1'b0};
        end else if (fail) begin
            m_item_next.bus_action = i2crrs_pkg::ACT_STOP;
            m_item_next.finished   = i2crrs_pkg::FIN_ERROR;
        end else if (timeout_hit) begin
            m_item_next.bus_action = i2crrs_pkg::ACT_STOP;
            m_item_next.finished   = i2crrs_pkg::FIN_TIMEOUT;
        end else if (addr_advance) begin
            unique case (phase_reg)
                i2crrs_pkg::PH_ADDR_W: begin
                    m_item_next.bus_action = i2crrs_pkg::ACT_WRITE;
                    m_item_next.tx_byte    = job_register_reg;
                end
                i2crrs_pkg::PH_REG: begin
                    m_item_next.bus_action = i2crrs_pkg::ACT_RESTART;
                    m_item_next.tx_byte    = {job_slave_reg, 1'b1};
                end
                default: begin
                    m_item_next.bus_action = i2crrs_pkg::ACT_BEGIN_RX;
                end
            endcase
        end else if (data_store) begin
            m_item_next.store_valid = 1'b1;
            m_item_next.store_byte  = s_item.rx_byte;
            m_item_next.store_index = read_count_reg ^ {15'd0, swap_bit};
            m_item_next.bus_action  = more ? i2crrs_pkg::ACT_CONTINUE_RX
                                           : i2crrs_pkg::ACT_STOP;
            m_item_next.finished    = more ? i2crrs_pkg::FIN_NONE
                                           : i2crrs_pkg::FIN_SUCCESS;
        end else begin
            m_item_next.bus_action = i2crrs_pkg::ACT_NONE;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= i2crrs_pkg::PH_IDLE;
            read_count_reg      <= 16'd0;
            timeout_counter_reg <= '0;
            timer_running_reg   <= 1'b0;
            nack_armed_reg      <= 1'b0;
            error_total_reg     <= 32'd0;
            cfg_slave_reg       <= 7'd0;
            cfg_register_reg    <= 8'd0;
            cfg_length_reg      <= 16'd0;
            job_slave_reg       <= 7'd0;
            job_register_reg    <= 8'd0;
            job_length_reg      <= 16'd0;
            m_valid_reg         <= 1'b0;
        end else begin
            phase_reg           <= phase_next;
            read_count_reg      <= read_count_next;
            timeout_counter_reg <= timeout_counter_next;
            timer_running_reg   <= timer_running_next;
            nack_armed_reg      <= nack_armed_next;
            error_total_reg     <= error_total_next;
            m_valid_reg         <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    i2crrs_pkg::CFG_SLAVE_ADDRESS: begin
                        cfg_slave_reg <= cfg_data[6:0];
                    end
                    i2crrs_pkg::CFG_REGISTER_ADDRESS: begin
                        cfg_register_reg <= cfg_data[7:0];
                    end
                    i2crrs_pkg::CFG_READ_LENGTH: begin
                        cfg_length_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (in_fire && start_ok) begin
                job_slave_reg    <= cfg_slave_reg;
                job_register_reg <= cfg_register_reg;
                job_length_reg   <= cfg_length_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_item_reg <= m_item_next;
        end
    end

endmodule

`default_nettype wire

/* tb/read_sequencer_checker.sv */
// checker that predicts and compares the result items of the i2c register read sequencer
`timescale 1ns / 100ps

module read_sequencer_checker #(
    parameter int TIMEOUT_TICKS = i2crrs_pkg::DEFAULT_TIMEOUT_TICKS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [i2crrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [i2crrs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  i2crrs_pkg::in_item_t                s_item,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  i2crrs_pkg::out_item_t               m_item,
    output int                                  fail_count,
    output int                                  pending
);
    import i2crrs_pkg::*;

    phase_t      phase;
    logic [15:0] read_count;
    int          ticks;
    logic        timer_on;
    logic        nack_armed;
    logic [31:0] failures;

    logic [6:0]  cfg_slave;
    logic [7:0]  cfg_reg;
    logic [15:0] cfg_len;
    logic [6:0]  job_slave;
    logic [7:0]  job_reg;
    logic [15:0] job_len;

    out_item_t   replies_due[$];
    out_item_t   want;
    int          mismatches = 0;

    function automatic void end_job();
        phase      = PH_IDLE;
        timer_on   = 1'b0;
        ticks      = 0;
        nack_armed = 1'b0;
    endfunction

    function automatic out_item_t step_sequencer(in_item_t it);
        out_item_t   r;
        logic        fail;
        logic [31:0] cnt32;
        logic [31:0] len32;
        r     = '0;
        fail  = 1'b0;
        cnt32 = {16'd0, read_count};
        len32 = {16'd0, job_len};
        case (it.kind)
            KIND_START: begin
                if (phase != PH_IDLE) begin
                    r.start_refused = 1'b1;
                end else if (cfg_len != 16'd0) begin
                    job_slave  = cfg_slave;
                    job_reg    = cfg_reg;
                    job_len    = cfg_len;
                    read_count = '0;
                    nack_armed = 1'b0;
                    phase      = PH_ADDR_W;
                    r.bus_action = ACT_START_WRITE;
                    r.tx_byte    = {cfg_slave, 1'b0};
                    timer_on   = 1'b1;
                    ticks      = 0;
                end
            end
            KIND_XFER: begin
                case (phase)
                    PH_ADDR_W: begin
                        if (it.nack_received) begin
                            fail = 1'b1;
                        end else begin
                            r.bus_action = ACT_WRITE;
                            r.tx_byte    = job_reg;
                            phase        = PH_REG;
                            timer_on     = 1'b1;
                            ticks        = 0;
                        end
                    end
                    PH_REG: begin
                        if (it.nack_received) begin
                            fail = 1'b1;
                        end else begin
                            if (job_len == 16'd1) nack_armed = 1'b1;
                            r.bus_action = ACT_RESTART;
                            r.tx_byte    = {job_slave, 1'b1};
                            phase        = PH_ADDR_R;
                            timer_on     = 1'b1;
                            ticks        = 0;
                        end
                    end
                    PH_ADDR_R: begin
                        if (it.nack_received) begin
                            fail = 1'b1;
                        end else begin
                            r.bus_action = ACT_BEGIN_RX;
                            phase        = PH_DUMMY;
                            timer_on     = 1'b1;
                            ticks        = 0;
                        end
                    end
                    PH_DUMMY, PH_DATA: begin
                        phase        = PH_DATA;
                        r.store_valid = 1'b1;
                        r.store_byte  = it.rx_byte;
                        if (cnt32 < len32 - 32'd1) begin
                            if (cnt32 == len32 - 32'd2) nack_armed = 1'b1;
                            r.store_index = read_count ^ 16'd1;
                            read_count    = read_count + 16'd1;
                            r.bus_action  = ACT_CONTINUE_RX;
                            timer_on      = 1'b1;
                            ticks         = 0;
                        end else begin
                            r.store_index = read_count ^ {15'd0, ~job_len[0]};
                            read_count    = read_count + 16'd1;
                            r.bus_action  = ACT_STOP;
                            r.finished    = FIN_SUCCESS;
                            end_job();
                        end
                    end
                    default: ;
                endcase
            end
            KIND_ARB_LOST: begin
                if (phase != PH_IDLE) fail = 1'b1;
            end
            default: begin
                if (timer_on && phase != PH_IDLE) begin
                    ticks = ticks + 1;
                    if (ticks >= TIMEOUT_TICKS) begin
                        failures     = failures + 32'd1;
                        r.bus_action = ACT_STOP;
                        r.finished   = FIN_TIMEOUT;
                        end_job();
                    end
                end
            end
        endcase
        if (fail) begin
            failures     = failures + 32'd1;
            r.bus_action = ACT_STOP;
            r.tx_byte    = '0;
            r.finished   = FIN_ERROR;
            end_job();
        end
        r.send_nack     = nack_armed;
        r.bytes_done    = read_count;
        r.failure_count = failures;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] got);
        if (exp !== got) begin
            $error("%s expected %0d got %0d", name, exp, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            end_job();
            read_count = '0;
            failures   = '0;
            cfg_slave  = '0;
            cfg_reg    = '0;
            cfg_len    = '0;
            job_slave  = '0;
            job_reg    = '0;
            job_len    = '0;
            replies_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("result item with nothing expected");
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("start_refused", 32'(want.start_refused),
                                32'(m_item.start_refused));
                    check_field("bus_action", 32'(want.bus_action), 32'(m_item.bus_action));
                    check_field("tx_byte", 32'(want.tx_byte), 32'(m_item.tx_byte));
                    check_field("send_nack", 32'(want.send_nack), 32'(m_item.send_nack));
                    check_field("store_valid", 32'(want.store_valid), 32'(m_item.store_valid));
                    check_field("store_index", 32'(want.store_index), 32'(m_item.store_index));
                    check_field("store_byte", 32'(want.store_byte), 32'(m_item.store_byte));
                    check_field("finished", 32'(want.finished), 32'(m_item.finished));
                    check_field("bytes_done", 32'(want.bytes_done), 32'(m_item.bytes_done));
                    check_field("failure_count", want.failure_count, m_item.failure_count);
                end
            end
            if (s_valid && s_ready) replies_due.push_back(step_sequencer(s_item));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SLAVE_ADDRESS:    cfg_slave = cfg_data[6:0];
                    CFG_REGISTER_ADDRESS: cfg_reg   = cfg_data[7:0];
                    CFG_READ_LENGTH:      cfg_len   = cfg_data;
                    default: ;
                endcase
            end
        end
        fail_count <= mismatches;
        pending    <= replies_due.size();
    end

endmodule

/* tb/tb_top.sv */
// testbench top that drives events and register writes into the i2c register read sequencer
`timescale 1ns / 100ps

module tb_top;
    import i2crrs_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_item_t               s_item = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_item;
    int                     fail_count;
    int                     pending;

    int          events_sent = 0;
    logic        s_calm = 1'b0;
    logic        m_calm = 1'b0;
    int          stall_left = 0;
    logic [15:0] cur_len = '0;

    i2c_register_read_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    read_sequencer_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) m_calm = !m_calm;
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!m_calm && $urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_event(input logic [1:0] k, input logic nk, input logic [7:0] rx);
        int r;
        int gap;
        s_item  <= '{kind: k, nack_received: nk, rx_byte: rx};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        events_sent++;
        if ($urandom_range(0, 99) == 0) s_calm = !s_calm;
        r = $urandom_range(0, 99);
        if (s_calm || r < 55) gap = 0;
        else if (r < 93) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 40);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_READ_LENGTH) cur_len = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ticks and refused starts between steps of a job
    task automatic stray_events();
        int n;
        if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, 3);
            repeat (n) send_event(KIND_TICK, 1'($urandom_range(0, 1)),
                                  8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 4)
            send_event(KIND_START, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    task automatic run_job();
        int          r;
        int          k;
        int          cap;
        int          n_data;
        logic [15:0] len;
        len = cur_len;
        if ($urandom_range(0, 9) == 0)
            send_event(2'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)));
        send_event(KIND_START, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        if (len == 16'd0) return;
        for (k = 0; k < 3; k++) begin
            stray_events();
            r = $urandom_range(0, 99);
            if (r < 4) begin
                send_event(KIND_XFER, 1'b1, 8'($urandom_range(0, 255)));
                return;
            end
            if (r < 6) begin
                send_event(KIND_ARB_LOST, 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)));
                return;
            end
            send_event(KIND_XFER, 1'b0, 8'($urandom_range(0, 255)));
        end
        cap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 24);
        n_data = (len < cap) ? len : cap;
        for (k = 0; k < n_data; k++) begin
            stray_events();
            if ($urandom_range(0, 99) < 2) begin
                send_event(KIND_ARB_LOST, 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)));
                return;
            end
            send_event(KIND_XFER, $urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
        end
        if (n_data < len)
            send_event(KIND_ARB_LOST, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int r;
        int jobs;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // events while idle, then a start with zero length
        send_event(KIND_XFER, 1'b1, 8'hFF);
        send_event(KIND_ARB_LOST, 1'b0, 8'h00);
        send_event(KIND_TICK, 1'b1, 8'h00);
        send_event(KIND_START, 1'b0, 8'h00);
        drain();

        // single byte read at the top address, with a refused start
        write_reg(CFG_SLAVE_ADDRESS, 16'd127);
        write_reg(CFG_REGISTER_ADDRESS, 16'd255);
        write_reg(CFG_READ_LENGTH, 16'd1);
        send_event(KIND_START, 1'b0, 8'h00);
        send_event(KIND_START, 1'b1, 8'hFF);
        send_event(KIND_XFER, 1'b0, 8'h00);
        send_event(KIND_XFER, 1'b0, 8'h00);
        send_event(KIND_XFER, 1'b0, 8'h00);
        send_event(KIND_XFER, 1'b1, 8'hA5);
        drain();

        // odd length read, nack on data ignored
        write_reg(CFG_SLAVE_ADDRESS, 16'd0);
        write_reg(CFG_REGISTER_ADDRESS, 16'd0);
        write_reg(CFG_READ_LENGTH, 16'd3);
        send_event(KIND_START, 1'b0, 8'h00);
        repeat (3) send_event(KIND_XFER, 1'b0, 8'h00);
        send_event(KIND_XFER, 1'b0, 8'h00);
        send_event(KIND_XFER, 1'b1, 8'hFF);
        send_event(KIND_XFER, 1'b0, 8'h5A);

        // address nack and arbitration loss
        send_event(KIND_START, 1'b0, 8'h00);
        send_event(KIND_XFER, 1'b1, 8'h00);
        send_event(KIND_START, 1'b0, 8'h00);
        send_event(KIND_XFER, 1'b0, 8'h00);
        send_event(KIND_ARB_LOST, 1'b0, 8'h00);

        // register write during a job only applies to the next one
        send_event(KIND_START, 1'b0, 8'h00);
        drain();
        write_reg(CFG_REGISTER_ADDRESS, 16'h003C);
        send_event(KIND_XFER, 1'b0, 8'h00);
        send_event(KIND_ARB_LOST, 1'b1, 8'hFF);
        drain();

        // a few ticks, progress restarts the count, then a real timeout
        write_reg(CFG_READ_LENGTH, 16'd5);
        send_event(KIND_START, 1'b0, 8'h00);
        repeat (10) send_event(KIND_TICK, 1'b0, 8'h00);
        send_event(KIND_XFER, 1'b0, 8'h00);
        repeat (DEFAULT_TIMEOUT_TICKS) send_event(KIND_TICK, 1'b0, 8'h00);
        send_event(KIND_TICK, 1'b0, 8'h00);

        while (events_sent < 1350) begin
            drain();
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_SLAVE_ADDRESS, 16'(($urandom_range(0, 3) == 0)
                          ? 127 * $urandom_range(0, 1) : $urandom_range(0, 127)));
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_REGISTER_ADDRESS, 16'(($urandom_range(0, 3) == 0)
                          ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255)));
            if ($urandom_range(0, 19) == 0)
                write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
            r = $urandom_range(0, 99);
            if (r < 8) write_reg(CFG_READ_LENGTH, 16'd0);
            else if (r < 18) write_reg(CFG_READ_LENGTH, 16'd1);
            else if (r < 26) write_reg(CFG_READ_LENGTH, 16'd2);
            else if (r < 31) write_reg(CFG_READ_LENGTH, 16'hFFFF);
            else if (r < 38) write_reg(CFG_READ_LENGTH, 16'($urandom_range(0, 65535)));
            else if (r < 70) write_reg(CFG_READ_LENGTH, 16'($urandom_range(3, 12)));
            jobs = $urandom_range(2, 6);
            repeat (jobs) run_job();
        end

        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/i2crrs_pkg.sv
rtl/core/i2c_register_read_sequencer.sv
tb/read_sequencer_checker.sv
tb/tb_top.sv
